// ===== rtl/core/fresnel_reflectance_defines.svh =====
// Assertion macros used by the fresnel reflectance top level.
`ifndef FRESNEL_REFLECTANCE_DEFINES_SVH
`define FRESNEL_REFLECTANCE_DEFINES_SVH

// Condition must hold at every edge outside reset.
`define FR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When ante holds, cons must hold in the same cycle.
`define FR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/fr_pkg.sv =====
// Package: fixed-point constants, register indexes and sideband types.
`timescale 1ns / 1ps
package fr_pkg;
	localparam int F = 15;
	localparam logic [16:0] ONE = 17'd1 << F;
	localparam logic [30:0] ONE_SQ = 31'd1 << (2 * F);

	localparam logic REG_COS_NEAR_ONE  = 1'b0;
	localparam logic REG_COS_NEAR_ZERO = 1'b1;

	typedef struct packed {
		logic [15:0] n1;
		logic [15:0] n2;
		logic [16:0] c;
		logic        eq;
		logic        n2z;
		logic        graze;
		logic [30:0] rad;
	} front_side_t;

	typedef struct packed {
		logic [15:0] n1;
		logic [15:0] n2;
		logic [16:0] c;
		logic        eq;
		logic        force_one;
	} mid_side_t;

	typedef struct packed {
		logic eq;
		logic force_one;
	} tail_side_t;

	typedef struct packed {
		tail_side_t tail;
		logic       ge;
	} div_side_t;
endpackage

// ===== rtl/core/fr_fdiv.sv =====
// Pipelined restoring fraction divider, one quotient bit per stage.
`timescale 1ns / 1ps
module fr_fdiv #(
	parameter int Q_W    = 15,
	parameter int NUM_W  = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [NUM_W-1:0]  num,
	input  logic [NUM_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_vld,
	output logic [Q_W-1:0]    quo,
	output logic [SIDE_W-1:0] side_out
);
	logic [NUM_W-1:0]  num_s  [Q_W];
	logic [NUM_W-1:0]  den_s  [Q_W];
	logic [Q_W-1:0]    q_s    [Q_W];
	logic [SIDE_W-1:0] side_s [Q_W];
	logic [Q_W-1:0]    vld_s;

	logic [NUM_W-1:0]  cur_num  [Q_W];
	logic [NUM_W-1:0]  cur_den  [Q_W];
	logic [Q_W-1:0]    cur_q    [Q_W];
	logic [SIDE_W-1:0] cur_side [Q_W];
	logic [NUM_W-1:0]  nxt_num  [Q_W];
	logic [Q_W-1:0]    nxt_q    [Q_W];

	always_comb begin
		logic [NUM_W:0] sh;
		logic           take;
		cur_num[0]  = num;
		cur_den[0]  = den;
		cur_q[0]    = '0;
		cur_side[0] = side_in;
		for (int k = 1; k < Q_W; k++) begin
			cur_num[k]  = num_s[k-1];
			cur_den[k]  = den_s[k-1];
			cur_q[k]    = q_s[k-1];
			cur_side[k] = side_s[k-1];
		end
		for (int k = 0; k < Q_W; k++) begin
			sh   = {cur_num[k], 1'b0};
			take = sh >= {1'b0, cur_den[k]};
			nxt_num[k] = take ? NUM_W'(sh - {1'b0, cur_den[k]}) : NUM_W'(sh);
			nxt_q[k]   = {cur_q[k][Q_W-2:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[Q_W-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < Q_W; k++) begin
				num_s[k]  <= nxt_num[k];
				den_s[k]  <= cur_den[k];
				q_s[k]    <= nxt_q[k];
				side_s[k] <= cur_side[k];
			end
		end
	end

	assign out_vld  = vld_s[Q_W-1];
	assign quo      = q_s[Q_W-1];
	assign side_out = side_s[Q_W-1];
endmodule

// ===== rtl/core/fr_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module fr_isqrt #(
	parameter int IN_W   = 31,
	parameter int OUT_W  = 16,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [IN_W-1:0]   rad,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_vld,
	output logic [OUT_W-1:0]  root,
	output logic [SIDE_W-1:0] side_out
);
	localparam int W = 2 * OUT_W + 1;

	logic [W-1:0]      rem_s  [OUT_W];
	logic [OUT_W-1:0]  root_s [OUT_W];
	logic [SIDE_W-1:0] side_s [OUT_W];
	logic [OUT_W-1:0]  vld_s;

	logic [W-1:0]      cur_rem  [OUT_W];
	logic [OUT_W-1:0]  cur_root [OUT_W];
	logic [SIDE_W-1:0] cur_side [OUT_W];
	logic [W-1:0]      nxt_rem  [OUT_W];
	logic [OUT_W-1:0]  nxt_root [OUT_W];

	// rem holds rad - root^2; adding bit b grows root^2 by root*2^(b+1) + 4^b
	always_comb begin
		logic [W-1:0] cand;
		cur_rem[0]  = W'(rad);
		cur_root[0] = '0;
		cur_side[0] = side_in;
		for (int k = 1; k < OUT_W; k++) begin
			cur_rem[k]  = rem_s[k-1];
			cur_root[k] = root_s[k-1];
			cur_side[k] = side_s[k-1];
		end
		for (int k = 0; k < OUT_W; k++) begin
			cand = (W'(cur_root[k]) << (OUT_W - k)) + (W'(1) << (2 * (OUT_W - 1 - k)));
			if (cur_rem[k] >= cand) begin
				nxt_rem[k]  = cur_rem[k] - cand;
				nxt_root[k] = cur_root[k] | (OUT_W'(1) << (OUT_W - 1 - k));
			end else begin
				nxt_rem[k]  = cur_rem[k];
				nxt_root[k] = cur_root[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[OUT_W-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < OUT_W; k++) begin
				rem_s[k]  <= nxt_rem[k];
				root_s[k] <= nxt_root[k];
				side_s[k] <= cur_side[k];
			end
		end
	end

	assign out_vld  = vld_s[OUT_W-1];
	assign root     = root_s[OUT_W-1];
	assign side_out = side_s[OUT_W-1];
endmodule

// ===== rtl/core/fresnel_reflectance.sv =====
// Top level: pipelined unpolarized Fresnel reflectance.
// Usage:
//  Input channel (in_valid/in_ready) carries index_incident, index_across
//  (unsigned Q2.14) and cos_incidence (signed Q1.15). Output channel
//  (out_valid/out_ready) returns reflect_prob (Q1.15, 32768 = 1.0) and
//  total_reflect, one result per input transaction, in order.
//  Throughput: one transaction per cycle while the receiver does not stall.
//  The pipeline chains bit-serial units: the 30-bit critical-cosine division,
//  a 15-step and two 16-step square roots, three 15-step divisions (the last
//  two side by side) and a few multiply/add stages.
//  All stages advance together; when the receiver stalls with a result
//  waiting, the whole pipeline freezes and in_ready drops in the same cycle,
//  so nothing is lost or repeated. Bubbles move on while out_valid is low.
//  Reset clears every stage valid bit and loads the limit registers
//  (near-one 32767, near-zero 0). cfg_we writes a limit in the same cycle;
//  write only while the pipeline is empty.
`timescale 1ns / 1ps
module fresnel_reflectance (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] index_incident,
	input  logic [15:0] index_across,
	input  logic signed [15:0] cos_incidence,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] reflect_prob,
	output logic        total_reflect
);
	import fr_pkg::*;
	`include "fresnel_reflectance_defines.svh"

	// global advance: the output register is empty or being drained
	logic en;

	// limit registers
	logic [15:0] lim_one_q;
	logic [15:0] lim_zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_one_q  <= 16'd32767;
			lim_zero_q <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COS_NEAR_ONE:  lim_one_q  <= cfg_data;
				REG_COS_NEAR_ZERO: lim_zero_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// s1: magnitude of cosine, squares of indices and cosine
	logic        vld_s1;
	logic [15:0] n1_s1, n2_s1;
	logic [16:0] c_s1;
	logic [31:0] n1sq_s1, n2sq_s1;
	logic [30:0] csq_s1;
	logic        eq_s1, n2z_s1, gt_s1;
	logic [15:0] raw;
	logic [16:0] c_in;

	assign raw  = $unsigned(cos_incidence);
	assign c_in = raw[15] ? 17'(17'h10000 - {1'b0, raw}) : {1'b0, raw};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n1_s1   <= index_incident;
			n2_s1   <= index_across;
			c_s1    <= c_in;
			n1sq_s1 <= index_incident * index_incident;
			n2sq_s1 <= index_across * index_across;
			csq_s1  <= 31'(c_in * c_in);
			eq_s1   <= index_incident == index_across;
			n2z_s1  <= index_across == 16'd0;
			gt_s1   <= index_incident > index_across;
		end
	end

	// s2: critical-cosine ratio operands, radicand for the incident sine
	logic        vld_s2;
	logic [31:0] ccn_s2, ccd_s2;
	front_side_t front_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ccn_s2         <= gt_s1 ? n1sq_s1 - n2sq_s1 : 32'd0;
			ccd_s2         <= gt_s1 ? n1sq_s1 : 32'd1;
			front_s2.n1    <= n1_s1;
			front_s2.n2    <= n2_s1;
			front_s2.c     <= c_s1;
			front_s2.eq    <= eq_s1;
			front_s2.n2z   <= n2z_s1;
			front_s2.graze <= c_s1 <= {1'b0, lim_zero_q};
			front_s2.rad   <= (c_s1 >= {1'b0, lim_one_q}) ? 31'd0 : ONE_SQ - csq_s1;
		end
	end

	// critical cosine: sqrt of (n1^2 - n2^2) / n1^2 scaled by 2^30
	logic        u1_vld, u2_vld;
	logic [29:0] u1_q;
	logic [14:0] cc;
	front_side_t u1_side, u2_side;

	fr_fdiv #(.Q_W(2 * F), .NUM_W(32), .SIDE_W($bits(front_side_t))) u_cc_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s2),
		.num(ccn_s2), .den(ccd_s2), .side_in(front_s2),
		.out_vld(u1_vld), .quo(u1_q), .side_out(u1_side)
	);

	fr_isqrt #(.IN_W(2 * F), .OUT_W(F), .SIDE_W($bits(front_side_t))) u_cc_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(u1_vld),
		.rad(u1_q), .side_in(u1_side),
		.out_vld(u2_vld), .root(cc), .side_out(u2_side)
	);

	// s3: at or below critical cosine, fold forced-one cases
	logic        vld_s3;
	logic [30:0] rad_s3;
	mid_side_t   mid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= u2_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3           <= u2_side.rad;
			mid_s3.n1        <= u2_side.n1;
			mid_s3.n2        <= u2_side.n2;
			mid_s3.c         <= u2_side.c;
			mid_s3.eq        <= u2_side.eq;
			mid_s3.force_one <= u2_side.n2z | u2_side.graze | (u2_side.c <= {2'b0, cc});
		end
	end

	// incident sine
	logic        u3_vld;
	logic [15:0] sin1;
	mid_side_t   u3_side;

	fr_isqrt #(.IN_W(31), .OUT_W(F + 1), .SIDE_W($bits(mid_side_t))) u_sin_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s3),
		.rad(rad_s3), .side_in(mid_s3),
		.out_vld(u3_vld), .root(sin1), .side_out(u3_side)
	);

	// s4: Snell numerator n1*s1 against n2 scaled to one
	logic        vld_s4;
	logic [31:0] snum_s4, sden_s4;
	mid_side_t   mid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= u3_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			snum_s4 <= u3_side.n1 * sin1;
			sden_s4 <= 32'({u3_side.n2, F'(0)});
			mid_s4  <= u3_side;
		end
	end

	// s5: transmitted sine reaching one
	logic        vld_s5;
	logic [31:0] snum_s5, sden_s5;
	mid_side_t   mid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			snum_s5          <= snum_s4;
			sden_s5          <= sden_s4;
			mid_s5.n1        <= mid_s4.n1;
			mid_s5.n2        <= mid_s4.n2;
			mid_s5.c         <= mid_s4.c;
			mid_s5.eq        <= mid_s4.eq;
			mid_s5.force_one <= mid_s4.force_one | (snum_s4 >= sden_s4);
		end
	end

	// transmitted sine = floor(n1*s1 / n2), below one here
	logic        u4_vld;
	logic [14:0] sin2;
	mid_side_t   u4_side;

	fr_fdiv #(.Q_W(F), .NUM_W(32), .SIDE_W($bits(mid_side_t))) u_snell_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s5),
		.num(snum_s5), .den(sden_s5), .side_in(mid_s5),
		.out_vld(u4_vld), .quo(sin2), .side_out(u4_side)
	);

	// s6/s7: radicand for transmitted cosine
	logic        vld_s6, vld_s7;
	logic [29:0] s2sq_s6;
	logic [30:0] rad_s7;
	mid_side_t   mid_s6, mid_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s6 <= u4_vld;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s2sq_s6 <= sin2 * sin2;
			mid_s6  <= u4_side;
			rad_s7  <= ONE_SQ - {1'b0, s2sq_s6};
			mid_s7  <= mid_s6;
		end
	end

	logic        u5_vld;
	logic [15:0] cos2;
	mid_side_t   u5_side;

	fr_isqrt #(.IN_W(31), .OUT_W(F + 1), .SIDE_W($bits(mid_side_t))) u_cos_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s7),
		.rad(rad_s7), .side_in(mid_s7),
		.out_vld(u5_vld), .root(cos2), .side_out(u5_side)
	);

	// s8: cross products; s9: difference and sum; s10: degenerate ratio
	logic        vld_s8, vld_s9, vld_s10;
	logic [32:0] x1_s8, y1_s8, x2_s8, y2_s8;
	logic [33:0] d1_s9, t1_s9, d2_s9, t2_s9;
	logic [33:0] d1_s10, t1_s10, d2_s10, t2_s10;
	logic        ge1_s10, ge2_s10;
	tail_side_t  tail_s8, tail_s9, tail_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s8  <= u5_vld;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s8             <= u5_side.n1 * u5_side.c;
			y1_s8             <= 33'(u5_side.n2 * cos2);
			x2_s8             <= 33'(u5_side.n1 * cos2);
			y2_s8             <= u5_side.n2 * u5_side.c;
			tail_s8.eq        <= u5_side.eq;
			tail_s8.force_one <= u5_side.force_one;

			d1_s9   <= 34'((x1_s8 > y1_s8) ? x1_s8 - y1_s8 : y1_s8 - x1_s8);
			t1_s9   <= {1'b0, x1_s8} + {1'b0, y1_s8};
			d2_s9   <= 34'((x2_s8 > y2_s8) ? x2_s8 - y2_s8 : y2_s8 - x2_s8);
			t2_s9   <= {1'b0, x2_s8} + {1'b0, y2_s8};
			tail_s9 <= tail_s8;

			d1_s10   <= d1_s9;
			t1_s10   <= t1_s9;
			d2_s10   <= d2_s9;
			t2_s10   <= t2_s9;
			ge1_s10  <= d1_s9 >= t1_s9;
			ge2_s10  <= d2_s9 >= t2_s9;
			tail_s10 <= tail_s9;
		end
	end

	// s-polarized and p-polarized amplitude ratios, two lanes in lockstep
	logic       u6_vld, u7_vld;
	logic [14:0] rs_q, rp_q;
	div_side_t  u6_in, u6_side;
	logic       u7_ge;

	assign u6_in.tail = tail_s10;
	assign u6_in.ge   = ge1_s10;

	fr_fdiv #(.Q_W(F), .NUM_W(34), .SIDE_W($bits(div_side_t))) u_rs_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s10),
		.num(d1_s10), .den(t1_s10), .side_in(u6_in),
		.out_vld(u6_vld), .quo(rs_q), .side_out(u6_side)
	);

	fr_fdiv #(.Q_W(F), .NUM_W(34), .SIDE_W(1)) u_rp_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s10),
		.num(d2_s10), .den(t2_s10), .side_in(ge2_s10),
		.out_vld(u7_vld), .quo(rp_q), .side_out(u7_ge)
	);

	// s11: squares of the ratios
	logic        vld_s11;
	logic [31:0] sq1_s11, sq2_s11;
	tail_side_t  tail_s11;
	logic [15:0] r1, r2;

	assign r1 = u6_side.ge ? ONE[15:0] : {1'b0, rs_q};
	assign r2 = u7_ge ? ONE[15:0] : {1'b0, rp_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s11 <= 1'b0;
		else if (en) vld_s11 <= u6_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq1_s11  <= r1 * r1;
			sq2_s11  <= r2 * r2;
			tail_s11 <= u6_side.tail;
		end
	end

	// s12: average with round half up, special-case select, output register
	logic        vld_s12;
	logic [15:0] prob_s12;
	logic        flag_s12;
	logic [32:0] sum;
	logic [16:0] r_avg;

	assign sum   = {1'b0, sq1_s11} + {1'b0, sq2_s11} + 33'(ONE);
	assign r_avg = sum[32:F+1] > ONE ? ONE : sum[32:F+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s12 <= 1'b0;
		else if (en) vld_s12 <= vld_s11;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (tail_s11.eq) begin
				prob_s12 <= 16'd0;
				flag_s12 <= 1'b0;
			end else if (tail_s11.force_one) begin
				prob_s12 <= ONE[15:0];
				flag_s12 <= 1'b1;
			end else begin
				prob_s12 <= r_avg[15:0];
				flag_s12 <= 1'b0;
			end
		end
	end

	assign en            = !vld_s12 || out_ready;
	assign in_ready      = en;
	assign out_valid     = vld_s12;
	assign reflect_prob  = prob_s12;
	assign total_reflect = flag_s12;

	`FR_ASSERT_ALWAYS(a_lanes_lockstep, clk, arst_n, u6_vld == u7_vld, "ratio lanes out of step")
	`FR_ASSERT_IMPLY(a_flag_is_one, clk, arst_n, out_valid && total_reflect, reflect_prob == ONE[15:0], "flag without one")
	`FR_ASSERT_IMPLY(a_prob_range, clk, arst_n, out_valid, reflect_prob <= ONE[15:0], "reflectance above one")
endmodule

// ===== verif/fresnel_reflectance_test.sv =====
// Testbench for fresnel_reflectance: random and directed transactions checked by a scoreboard.
`timescale 1ns / 1ps
module fresnel_reflectance_test;
	import fr_pkg::*;

	// One expected result in the output stream
	typedef struct {
		logic [15:0] prob;
		logic        flag;
	} reflectance_t;

	// Predicts reflectance for accepted inputs and checks results in order
	class reflectance_scoreboard;
		bit [63:0]    near_one_limit;
		bit [63:0]    near_zero_limit;
		reflectance_t awaited[$];
		int           mismatches;
		int           results_seen;
		int           forced_seen;

		function new();
			near_one_limit = 32767;
			near_zero_limit = 0;
			mismatches = 0;
			results_seen = 0;
			forced_seen = 0;
		endfunction

		function bit [63:0] int_sqrt(bit [63:0] v);
			bit [63:0] root;
			bit [63:0] b;
			root = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= root + b) begin
					v -= root + b;
					root = (root >> 1) + b;
				end else begin
					root >>= 1;
				end
				b >>= 2;
			end
			return root;
		endfunction

		// floor(num * 2^nbits / den), saturating to 2^nbits when num >= den
		function bit [63:0] scaled_quotient(bit [63:0] num, bit [63:0] den, int nbits);
			bit [63:0] q;
			q = 0;
			if (den == 0 || num >= den)
				return 64'd1 << nbits;
			for (int i = 0; i < nbits; i++) begin
				num <<= 1;
				q <<= 1;
				if (num >= den) begin
					num -= den;
					q |= 1;
				end
			end
			return q;
		endfunction

		function bit [63:0] amplitude_sq(bit [63:0] x, bit [63:0] y);
			bit [63:0] r;
			r = scaled_quotient((x > y) ? x - y : y - x, x + y, F);
			return r * r;
		endfunction

		function reflectance_t predict(bit [15:0] n1_in, bit [15:0] n2_in, bit [15:0] raw);
			bit [63:0]    unit;
			bit [63:0]    n1;
			bit [63:0]    n2;
			bit [63:0]    c;
			bit [63:0]    crit;
			bit [63:0]    s1;
			bit [63:0]    s2;
			bit [63:0]    c2;
			bit [63:0]    r;
			reflectance_t res;
			unit = 64'd1 << F;
			n1 = 64'(n1_in);
			n2 = 64'(n2_in);
			c = raw[15] ? 64'h10000 - 64'(raw) : 64'(raw);
			if (c > unit)
				c = unit;
			res.prob = unit[15:0];
			res.flag = 1'b1;
			if (n1 == n2) begin
				res.prob = '0;
				res.flag = 1'b0;
				return res;
			end
			if (n2 == 0)
				return res;
			crit = 0;
			if (n1 > n2)
				crit = int_sqrt(scaled_quotient(n1 * n1 - n2 * n2, n1 * n1, 2 * F));
			if (c <= crit || c <= near_zero_limit)
				return res;
			s1 = (c >= near_one_limit) ? 0 : int_sqrt((64'd1 << (2 * F)) - c * c);
			s2 = (n1 * s1) / n2;
			if (s2 >= unit)
				return res;
			c2 = int_sqrt((64'd1 << (2 * F)) - s2 * s2);
			r = (amplitude_sq(n1 * c, n2 * c2) + amplitude_sq(n1 * c2, n2 * c) + unit)
				>> (F + 1);
			if (r > unit)
				r = unit;
			res.prob = r[15:0];
			res.flag = 1'b0;
			return res;
		endfunction

		function void note_input(bit [15:0] n1, bit [15:0] n2, bit [15:0] raw);
			awaited.push_back(predict(n1, n2, raw));
		endfunction

		function void check_result(logic [15:0] prob, logic flag);
			reflectance_t want;
			results_seen++;
			if (flag === 1'b1)
				forced_seen++;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result prob=%0d flag=%b", prob, flag);
				return;
			end
			want = awaited.pop_front();
			if (prob !== want.prob || flag !== want.flag) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result %0d: expected prob=%0d flag=%b, got prob=%0d flag=%b",
						results_seen, want.prob, want.flag, prob, flag);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [15:0] index_incident;
	logic [15:0] index_across;
	logic signed [15:0] cos_incidence;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] reflect_prob;
	logic        total_reflect;

	reflectance_scoreboard sb = new();
	int sent;
	bit burst_mode;  // when set, neither side idles

	fresnel_reflectance u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.index_incident(index_incident),
		.index_across(index_across),
		.cos_incidence(cos_incidence),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.reflect_prob(reflect_prob),
		.total_reflect(total_reflect)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#4ms;
		$display("fresnel_reflectance_test failed");
		$finish;
	end

	// Mostly short gaps, occasionally a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (burst_mode || roll < 60)
			return 0;
		if (roll < 93)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Receiver: random backpressure, driven at the falling edge
	initial begin
		int hold;
		out_ready = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				hold = pick_gap();
				out_ready <= (hold == 0);
			end
		end
	end

	// Results are sampled at the rising edge
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(reflect_prob, total_reflect);

	// Send one transaction; valid stays up across back-to-back items.
	// Entered and left at a falling edge.
	task automatic send_item(bit [15:0] n1, bit [15:0] n2, bit [15:0] raw);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		index_incident <= n1;
		index_across <= n2;
		cos_incidence <= raw;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_input(n1, n2, raw);
		sent++;
		@(negedge clk);
	endtask

	// Registers only change with the pipeline drained
	task automatic write_limit(logic idx, bit [15:0] value);
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(negedge clk);
		repeat (130) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == REG_COS_NEAR_ONE)
			sb.near_one_limit = 64'(value);
		else
			sb.near_zero_limit = 64'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic bit [15:0] random_index();
		return 16'($urandom_range(65535, 16384));
	endfunction

	// Random boundary hit: mostly plausible media, some equal or extreme indices
	task automatic send_random();
		bit [15:0] n1;
		bit [15:0] n2;
		bit [15:0] raw;
		int roll;
		roll = $urandom_range(99);
		n1 = random_index();
		if (roll < 10)
			n2 = n1;
		else if (roll < 60)
			n2 = (n1 > 16384 + 4000) ? n1 - 16'($urandom_range(4000))
				: n1 + 16'($urandom_range(4000));
		else
			n2 = random_index();
		roll = $urandom_range(99);
		if (roll < 8)
			raw = 16'h8000;
		else if (roll < 16)
			raw = 16'($urandom_range(32767, 32700));
		else if (roll < 24)
			raw = 16'(-$urandom_range(300));
		else
			raw = 16'($urandom);
		send_item(n1, n2, raw);
	endtask

	initial begin
		bit [15:0] one_lim[5];
		bit [15:0] zero_lim[5];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_COS_NEAR_ONE;
		cfg_data = '0;
		in_valid = 1'b0;
		index_incident = 16'd16384;
		index_across = 16'd16384;
		cos_incidence = '0;
		sent = 0;
		burst_mode = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: equal indices, both directions of index step, critical
		// angle, grazing and normal incidence, cosine sign and saturation
		send_item(16'd16384, 16'd16384, 16'sd12345);
		send_item(16'd65535, 16'd65535, -16'sd1);
		send_item(16'd24576, 16'd16384, 16'sd32767);
		send_item(16'd24576, 16'd16384, 16'sd1000);
		send_item(16'd24576, 16'd16384, 16'sd24426);
		send_item(16'd24576, 16'd16384, 16'sd24427);
		send_item(16'd16384, 16'd24576, 16'sd0);
		send_item(16'd16384, 16'd24576, 16'sd1);
		send_item(16'd16384, 16'd24576, 16'h8000);
		send_item(16'd16384, 16'd24576, -16'sd32767);
		send_item(16'd16384, 16'd24576, 16'sd32766);
		send_item(16'd16384, 16'd65535, 16'sd20000);
		send_item(16'd65535, 16'd16384, 16'sd32767);
		send_item(16'd65535, 16'd16384, 16'sd31000);
		send_item(16'd65535, 16'd65534, 16'sd5000);
		send_item(16'd21954, 16'd16384, -16'sd18000);
		send_item(16'd16384, 16'd21954, 16'sd100);
		send_item(16'd32768, 16'd49151, 16'sd16384);
		send_item(16'd49151, 16'd32768, -16'sd16384);
		send_item(16'd40000, 16'd40001, 16'sd2);

		// Limit settings per phase, extremes included
		one_lim = '{16'd32767, 16'd32768, 16'd0, 16'd30000, 16'd32000};
		zero_lim = '{16'd0, 16'd32768, 16'd0, 16'd3000, 16'd200};
		for (int p = 0; p < 5; p++) begin
			write_limit(REG_COS_NEAR_ONE, one_lim[p]);
			write_limit(REG_COS_NEAR_ZERO, zero_lim[p]);
			// Incidence at the near-one and near-zero limit edges under each setting
			send_item(16'd16384, 16'd24576, one_lim[p]);
			send_item(16'd24576, 16'd16384, zero_lim[p]);
			for (int i = 0; i < 86; i++) begin
				if (i % 30 == 0)
					burst_mode = 1'($urandom_range(1));
				send_random();
			end
			burst_mode = 1'b0;
		end
		in_valid <= 1'b0;

		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
		$display("Covered %0d transactions over 5 limit settings; %0d results, %0d forced to one.",
			sent, sb.results_seen, sb.forced_seen);
		if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
			$display("fresnel_reflectance_test passed");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches, sb.awaited.size());
			$display("fresnel_reflectance_test failed");
		end
		$finish;
	end
endmodule
